// ===== rtl/core/matrix3_inverse_adjugate_unit_defines.svh =====
// Assertion macros shared by the 3x3 matrix inverse unit.
`ifndef MATRIX3_INVERSE_ADJUGATE_UNIT_DEFINES_SVH
`define MATRIX3_INVERSE_ADJUGATE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M3INV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("m3inv check failed");

// The consequent must hold in the cycle after the antecedent.
`define M3INV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("m3inv check failed");

`endif

// ===== rtl/core/m3inv_pkg.sv =====
// Shared constants and types of the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
package m3inv_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int EPS_WIDTH      = 31;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 31'd1;
  localparam int FRONT_STAGES   = 8;

  localparam logic [0:0] REG_IDX_EPS = 1'b0;

  // Entries (a, b, c, d) of cofactor k, computed as e[a]*e[b] - e[c]*e[d].
  localparam logic [3:0] COF_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd2, 4'd3, 4'd0, 4'd5}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic en;
    logic singular;
    logic neg;
  } lane_ctl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/m3inv_if.sv =====
// Valid/ready channel interfaces for matrix items and result items.
`timescale 1ns / 1ps
interface m3inv_in_if #(
  parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF
) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface m3inv_out_if #(
  parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF
) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic invertible;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  invertible, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                invertible, output ready);
endinterface

// ===== rtl/core/matrix3_inverse_adjugate_unit.sv =====
// Throughput: one item per cycle while the output buffer is not full.
// The depth is set by the nine divider lanes, one bit per stage.
// A stalled output holds the pipeline only once the two-entry output buffer is full.
// Reset clears all valid bits, empties the output buffer and sets singular_epsilon to 1.
// Top level of the 3x3 matrix inverse unit by the adjugate method.
`timescale 1ns / 1ps
`include "matrix3_inverse_adjugate_unit_defines.svh"
module matrix3_inverse_adjugate_unit #(
  parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3inv_in_if.sink     in_i,
  m3inv_out_if.source  out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2*W;
  localparam int CW   = 2*W + 1;
  localparam int DTW  = 3*W + 1;
  localparam int DMW  = 3*W;
  localparam int AMW  = 2*W - 1;
  localparam int NW   = m3inv_pkg::max_int(2*W+2*F, 3*W) + 1;
  localparam int SW   = m3inv_pkg::max_int(AMW+1, W+1);
  localparam int EW   = m3inv_pkg::max_int(DMW+1, m3inv_pkg::EPS_WIDTH);
  localparam int LAT  = m3inv_pkg::FRONT_STAGES + W + 1;
  localparam int OW   = 9*W + 1;

  // Configuration port.
  logic [m3inv_pkg::EPS_WIDTH-1:0] eps_q;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == m3inv_pkg::REG_IDX_EPS);
  assign prdata = (paddr[2:2] == m3inv_pkg::REG_IDX_EPS) ? 32'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= m3inv_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      eps_q <= pwdata[m3inv_pkg::EPS_WIDTH-1:0];
    end
  end

  // Pipeline control.
  logic [1:0] cnt_q;
  logic       en;
  logic       v_q [LAT];
  logic       push;
  logic       pop;

  assign en         = (cnt_q != 2'd2);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_i.valid;
      for (int i = 1; i < LAT; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Stage 1: input capture.
  logic signed [W-1:0] e_in [9];
  logic signed [W-1:0] e1_q [9];

  assign e_in[0] = in_i.m00;
  assign e_in[1] = in_i.m01;
  assign e_in[2] = in_i.m02;
  assign e_in[3] = in_i.m10;
  assign e_in[4] = in_i.m11;
  assign e_in[5] = in_i.m12;
  assign e_in[6] = in_i.m20;
  assign e_in[7] = in_i.m21;
  assign e_in[8] = in_i.m22;

  always_ff @(posedge clk_i) begin
    if (en) e1_q <= e_in;
  end

  // Stage 2: pairwise products for the cofactors.
  logic signed [PW-1:0] pr_q [18];
  logic signed [W-1:0]  e2_q [3];
  logic signed [W-1:0]  e3_q [3];

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en) begin
        pr_q[2*k]   <= e1_q[m3inv_pkg::COF_IDX[k][0]] * e1_q[m3inv_pkg::COF_IDX[k][1]];
        pr_q[2*k+1] <= e1_q[m3inv_pkg::COF_IDX[k][2]] * e1_q[m3inv_pkg::COF_IDX[k][3]];
      end
    end
  end

  // Stage 3: cofactors.
  logic signed [CW-1:0] cof3_q [9];
  logic signed [CW-1:0] cof4_q [9];
  logic signed [CW-1:0] cof5_q [9];
  logic signed [CW-1:0] cof6_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e2_q[i] <= e1_q[i];
        e3_q[i] <= e2_q[i];
      end
      for (int k = 0; k < 9; k++) begin
        cof3_q[k] <= CW'(pr_q[2*k]) - CW'(pr_q[2*k+1]);
      end
      cof4_q <= cof3_q;
      cof5_q <= cof4_q;
      cof6_q <= cof5_q;
    end
  end

  // Stages 4 to 6: determinant along row 0, each wide product split in two halves.
  logic signed [CW-1:0]  dlo_q  [3];
  logic signed [CW-1:0]  dhi_q  [3];
  logic signed [DTW-1:0] term_q [3];
  logic signed [DTW-1:0] det_q;

  for (genvar k = 0; k < 3; k++) begin : g_det
    logic signed [W:0] cof_lo;
    logic signed [W:0] cof_hi;

    assign cof_lo = $signed({1'b0, cof3_q[k][W-1:0]});
    assign cof_hi = $signed(cof3_q[k][2*W:W]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        dlo_q[k]  <= e3_q[k] * cof_lo;
        dhi_q[k]  <= e3_q[k] * cof_hi;
        term_q[k] <= (DTW'(dhi_q[k]) <<< W) + DTW'(dlo_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) det_q <= term_q[0] + term_q[1] + term_q[2];
  end

  // Stage 7: magnitudes and signs; the adjugate is the transposed cofactor matrix.
  logic [DMW-1:0] dmag_q;
  logic           dneg_q;
  logic [AMW-1:0] amag_q [9];
  logic           aneg_q [9];
  logic [DTW-1:0] det_abs;

  assign det_abs = det_q[DTW-1] ? DTW'(-det_q) : DTW'(det_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= det_q[DTW-1];
      dmag_q <= det_abs[DMW-1:0];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_adj
    localparam int SRC = 3*(k%3) + k/3;
    logic [CW-1:0] cabs;

    assign cabs = cof6_q[SRC][CW-1] ? CW'(-cof6_q[SRC]) : CW'(cof6_q[SRC]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        aneg_q[k] <= cof6_q[SRC][CW-1];
        amag_q[k] <= cabs[AMW-1:0];
      end
    end
  end

  // Stage 8: singular test, dividend and divisor, rounded adjugate.
  logic [EW-1:0] det_rnd;
  logic          sing_d;
  logic          sing_q;
  logic [NW-1:0] num_q  [9];
  logic [DMW:0]  den_q;
  logic [W-1:0]  sval_q [9];
  logic          neg_q  [9];

  assign det_rnd = (EW'(dmag_q) + (EW'(1) << (2*F-1))) >> (2*F);
  assign sing_d  = (dmag_q == '0) || (det_rnd < EW'(eps_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= sing_d;
      den_q  <= {dmag_q, 1'b0};
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_pre
    logic [SW-1:0] rnd;
    logic [W-1:0]  sval_d;

    assign rnd = (SW'(amag_q[k]) + (SW'(1) << (F-1))) >> F;

    always_comb begin
      if (!aneg_q[k]) begin
        if (rnd > ((SW'(1) << (W-1)) - SW'(1))) begin
          sval_d = {1'b0, {(W-1){1'b1}}};
        end else begin
          sval_d = rnd[W-1:0];
        end
      end else begin
        if (rnd > (SW'(1) << (W-1))) begin
          sval_d = {1'b1, {(W-1){1'b0}}};
        end else begin
          sval_d = -rnd[W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[k]  <= (NW'(amag_q[k]) << (2*F+1)) + NW'(dmag_q);
        sval_q[k] <= sval_d;
        neg_q[k]  <= aneg_q[k] ^ dneg_q;
      end
    end
  end

  // Divider lanes.
  logic [W-1:0] res [9];
  logic         lane_sing [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3inv_pkg::lane_ctl_t ctl;

    assign ctl.en       = en;
    assign ctl.singular = sing_q;
    assign ctl.neg      = neg_q[k];

    m3inv_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .num_i      (num_q[k]),
      .den_i      (den_q),
      .sval_i     (sval_q[k]),
      .res_o      (res[k]),
      .singular_o (lane_sing[k])
    );
  end

  // Two-entry output buffer.
  logic [OW-1:0] buf_q [2];
  logic          wptr_q;
  logic          rptr_q;
  logic [OW-1:0] wdata;
  logic [OW-1:0] rdata;

  assign push  = v_q[LAT-1] && en;
  assign pop   = out_o.valid && out_o.ready;
  assign wdata = {!lane_sing[0], res[8], res[7], res[6], res[5], res[4],
                  res[3], res[2], res[1], res[0]};

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata            = buf_q[rptr_q];
  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.r00        = rdata[0*W +: W];
  assign out_o.r01        = rdata[1*W +: W];
  assign out_o.r02        = rdata[2*W +: W];
  assign out_o.r10        = rdata[3*W +: W];
  assign out_o.r11        = rdata[4*W +: W];
  assign out_o.r12        = rdata[5*W +: W];
  assign out_o.r20        = rdata[6*W +: W];
  assign out_o.r21        = rdata[7*W +: W];
  assign out_o.r22        = rdata[8*W +: W];
  assign out_o.invertible = rdata[OW-1];

  `M3INV_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `M3INV_ASSERT_NEXT(a_stall_keeps_item, clk_i, rst_ni, !en && v_q[LAT-1], v_q[LAT-1])
  `M3INV_ASSERT_IMPL(a_lanes_agree, clk_i, rst_ni, v_q[LAT-1], lane_sing[0] == lane_sing[8])
  `M3INV_ASSERT_NEXT(a_push_counts, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

// ===== rtl/core/m3inv_div.sv =====
// Pipelined rounding divider lane with saturation, one quotient bit per stage.
`timescale 1ns / 1ps
module m3inv_div #(
  parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  m3inv_pkg::lane_ctl_t              ctl_i,
  input  logic [m3inv_pkg::max_int(2*DATA_WIDTH+2*FRAC_BITS, 3*DATA_WIDTH):0] num_i,
  input  logic [3*DATA_WIDTH:0]             den_i,
  input  logic [DATA_WIDTH-1:0]             sval_i,
  output logic [DATA_WIDTH-1:0]             res_o,
  output logic                              singular_o
);

  localparam int W    = DATA_WIDTH;
  localparam int NW   = m3inv_pkg::max_int(2*W+2*FRAC_BITS, 3*W) + 1;
  localparam int DNW  = 3*W + 1;
  localparam int CMPW = m3inv_pkg::max_int(NW-W, DNW);

  logic [DNW-1:0] rem_q  [W+1];
  logic [DNW-1:0] den_q  [W+1];
  logic [W-1:0]   nlo_q  [W+1];
  logic [W-1:0]   quo_q  [W+1];
  logic           ovf_q  [W+1];
  logic           neg_q  [W+1];
  logic           sing_q [W+1];
  logic [W-1:0]   sval_q [W+1];

  logic [CMPW-1:0] num_hi;
  logic [NW-1:0]   num_sh;

  assign num_sh = num_i >> W;
  assign num_hi = CMPW'(num_sh);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ovf_q[0]  <= (num_hi >= CMPW'(den_i));
      rem_q[0]  <= DNW'(num_hi);
      den_q[0]  <= den_i;
      nlo_q[0]  <= num_i[W-1:0];
      quo_q[0]  <= '0;
      neg_q[0]  <= ctl_i.neg;
      sing_q[0] <= ctl_i.singular;
      sval_q[0] <= sval_i;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic [DNW:0] shifted;
    logic [DNW:0] diff;
    logic         ge;

    assign shifted = {rem_q[j], nlo_q[j][W-1]};
    assign diff    = shifted - {1'b0, den_q[j]};
    assign ge      = (shifted >= {1'b0, den_q[j]});

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[j+1]  <= ge ? diff[DNW-1:0] : shifted[DNW-1:0];
        quo_q[j+1]  <= {quo_q[j][W-2:0], ge};
        nlo_q[j+1]  <= {nlo_q[j][W-2:0], 1'b0};
        den_q[j+1]  <= den_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        neg_q[j+1]  <= neg_q[j];
        sing_q[j+1] <= sing_q[j];
        sval_q[j+1] <= sval_q[j];
      end
    end
  end

  logic [W-1:0] quo;
  logic [W-1:0] sat_val;

  assign quo = quo_q[W];

  always_comb begin
    if (!neg_q[W]) begin
      if (ovf_q[W] || quo[W-1]) begin
        sat_val = {1'b0, {(W-1){1'b1}}};
      end else begin
        sat_val = quo;
      end
    end else begin
      if (ovf_q[W] || (quo[W-1] && |quo[W-2:0])) begin
        sat_val = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_val = -quo;
      end
    end
  end

  assign res_o      = sing_q[W] ? sval_q[W] : sat_val;
  assign singular_o = sing_q[W];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 3x3 matrix inverse unit: random and directed items with a predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY = m3inv_pkg::DATA_WIDTH_DEF + 9;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] EPS_ADDR = 3'd0;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] m [9];
  } matrix_t;

  typedef struct {
    logic [31:0] r [9];
    logic        invertible;
  } inverse_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  m3inv_in_if  in_if ();
  m3inv_out_if out_if ();

  matrix3_inverse_adjugate_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  matrix_t  pending_matrices [$];
  inverse_t expected_inverses [$];
  matrix_t  driven_matrix;
  logic [30:0] eps_shadow;
  int fail_count;
  int cycle_count;
  int burst_left;
  int gap_left;
  int stall_mode;

  // Cofactor k is e[a]*e[b] - e[c]*e[d].
  localparam int CofTerms [9][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  function automatic logic [31:0] saturate_q16(input logic neg, input logic [255:0] q);
    if (!neg) begin
      return (q > 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return (q > 256'h8000_0000) ? 32'h8000_0000 : -q[31:0];
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t x, input logic [30:0] eps);
    logic signed [127:0] e [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det;
    logic signed [127:0] a;
    logic [255:0] det_mag, a_mag, num, den;
    logic singular;
    inverse_t res;
    for (int k = 0; k < 9; k++) e[k] = x.m[k];
    for (int k = 0; k < 9; k++) begin
      cof[k] = e[CofTerms[k][0]] * e[CofTerms[k][1]] - e[CofTerms[k][2]] * e[CofTerms[k][3]];
    end
    det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
    det_mag = (det < 0) ? -det : det;
    singular = (det == 0) || (((det_mag + (256'd1 << 31)) >> 32) < 256'(eps));
    for (int k = 0; k < 9; k++) begin
      a = cof[3 * (k % 3) + k / 3];
      a_mag = (a < 0) ? -a : a;
      if (singular) begin
        res.r[k] = saturate_q16(a < 0, (a_mag + (256'd1 << 15)) >> 16);
      end else begin
        num = (a_mag << 33) + det_mag;
        den = det_mag << 1;
        res.r[k] = saturate_q16((a < 0) != (det < 0), num / den);
      end
    end
    res.invertible = !singular;
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0;
    in_if.m00 = '0; in_if.m01 = '0; in_if.m02 = '0; in_if.m10 = '0; in_if.m11 = '0;
    in_if.m12 = '0; in_if.m20 = '0; in_if.m21 = '0; in_if.m22 = '0;
    out_if.ready = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_inverses.push_back(invert_matrix(driven_matrix, eps_shadow));
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left == 0 && pending_matrices.size() > 0) begin
          driven_matrix = pending_matrices.pop_front();
          in_if.valid <= 1'b1;
          in_if.m00 <= driven_matrix.m[0]; in_if.m01 <= driven_matrix.m[1];
          in_if.m02 <= driven_matrix.m[2]; in_if.m10 <= driven_matrix.m[3];
          in_if.m11 <= driven_matrix.m[4]; in_if.m12 <= driven_matrix.m[5];
          in_if.m20 <= driven_matrix.m[6]; in_if.m21 <= driven_matrix.m[7];
          in_if.m22 <= driven_matrix.m[8];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random periodically.
  always @(posedge clk_i) begin
    inverse_t want;
    logic [31:0] got [9];
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.r00, out_if.r01, out_if.r02, out_if.r10, out_if.r11,
                out_if.r12, out_if.r20, out_if.r21, out_if.r22};
        if (expected_inverses.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_inverses.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k] !== want.r[k]) begin
              $error("r%0d%0d expected %h actual %h", k / 3, k % 3, want.r[k], got[k]);
              fail_count++;
            end
          end
          if (out_if.invertible !== want.invertible) begin
            $error("invertible expected %b actual %b", want.invertible, out_if.invertible);
            fail_count++;
          end
        end
      end
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (cycle_count % 16) < 12;
      endcase
    end
  end

  task automatic write_epsilon(input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= EPS_ADDR; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eps_shadow = value[30:0];
  endtask

  task automatic wait_drained();
    while (pending_matrices.size() > 0 || in_if.valid || expected_inverses.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic add_matrix(input logic signed [31:0] a, b, c, d, f, g, h, i, j);
    matrix_t x;
    x.m = '{a, b, c, d, f, g, h, i, j};
    pending_matrices.push_back(x);
  endtask

  function automatic logic signed [31:0] random_entry(input int style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 ** 19)) - 2 ** 18;
      2: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
      default: return $signed($urandom_range(0, 2 ** 13)) - 2 ** 12;
    endcase
  endfunction

  task automatic add_random_matrices(input int count);
    matrix_t x;
    int style;
    for (int n = 0; n < count; n++) begin
      style = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) x.m[k] = random_entry(style);
      if ($urandom_range(0, 7) == 0) begin
        for (int k = 0; k < 3; k++) x.m[6 + k] = x.m[3 * $urandom_range(0, 1) + k];
      end
      pending_matrices.push_back(x);
    end
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    burst_left = 8;
    gap_left = 0;
    stall_mode = 0;
    eps_shadow = m3inv_pkg::EPS_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    add_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_matrix(ONE <<< 1, 0, 0, 0, ONE <<< 2, 0, 0, 0, -(ONE <<< 3));
    add_matrix(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    add_matrix(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
    add_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
    add_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
    add_matrix(MINV, MAXV, 0, MAXV, MINV, MAXV, 0, MAXV, MINV);
    add_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_matrix(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE);
    add_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
    add_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE);
    add_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1);
    add_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256);
    add_matrix(ONE >>> 8, 0, 0, 0, ONE, 0, 0, 0, ONE);
    add_matrix(3 * ONE, MINV, 1, -1, 7 * ONE, MAXV, ONE, -ONE, 2);
    add_random_matrices(80);
    wait_drained();

    write_epsilon(32'h0000_0000);
    add_matrix(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE);
    add_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256);
    add_random_matrices(90);
    wait_drained();

    write_epsilon(32'hFFFF_FFFF);
    add_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
    add_random_matrices(90);
    wait_drained();

    write_epsilon(32'h8001_0000);
    add_random_matrices(90);
    wait_drained();

    write_epsilon($urandom);
    add_random_matrices(90);
    wait_drained();

    write_epsilon(32'h0000_0001);
    add_random_matrices(90);
    wait_drained();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
